// ===== rtl/core/dwconv_pkg.sv =====
// shared types, widths, register codes and the sigmoid table for the
// causal depthwise conv step block; no dependencies
`default_nettype none

package dwconv_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int NUM_TAPS      = 4;
  localparam int TAP_IDX_W     = $clog2(NUM_TAPS);
  localparam int KERNEL_DEF    = 4;
  localparam int HIST_LEN_DEF  = 3;

  // accumulator covers four full-scale products plus the shifted bias
  localparam int ACC_W   = 35;
  localparam int FRAC_W  = 12;
  localparam int X_W     = ACC_W - FRAC_W;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = X_W + MUL_B_W;
  localparam int SIG_W   = 17;

  localparam logic [SIG_W-1:0] SIG_ONE = 17'd65536;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SILU = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_SIG,
    ST_SILU,
    ST_DONE
  } dwconv_state_e;

  // sigmoid of 0..8 in Q.16
  function automatic logic [15:0] sig_lut(input logic [3:0] idx);
    logic [15:0] val;
    case (idx)
      4'd0:    val = 16'd32768;
      4'd1:    val = 16'd47911;
      4'd2:    val = 16'd57724;
      4'd3:    val = 16'd62428;
      4'd4:    val = 16'd64357;
      4'd5:    val = 16'd65097;
      4'd6:    val = 16'd65374;
      4'd7:    val = 16'd65476;
      4'd8:    val = 16'd65514;
      default: val = 16'd65514;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/causal_depthwise_conv_step_top.sv =====
// causal fir step with optional silu activation, one channel, q4.12 data
// depends on dwconv_pkg (widths, state enum, register codes, sigmoid table)
`default_nettype none

// channel     | dir | payload                          | handshake
// ------------+-----+----------------------------------+-----------------------
// s_axis      | in  | tdata[15:0] sample_in            | tvalid / tready
// m_axis      | out | tdata[15:0] result_out,          | tvalid / tready
//             |     | tuser[0] saturated               |
// cfg         | in  | cfg_index_i, cfg_wdata_i         | cfg_we_i, no wait
//
// an item goes from accept through the mac and round states, with silu on also
// the sig and silu states, to the done state that loads the output register;
// one 23x18 multiplier is shared by the tap mac (one tap per cycle), the sigmoid
// interpolation and the final x*s
// the block is ready only in idle; a result waiting in the output register
// does not block the next accept, only the load of the following result
// reset clears history, taps, bias, silu enable and the output valid

module causal_depthwise_conv_step_top
  import dwconv_pkg::*;
#(
  parameter int KERNEL    = KERNEL_DEF,
  parameter int HIST_LEN  = HIST_LEN_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  // sample stream
  input  wire                       s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire  [15:0]               s_axis_tdata,   // [15:0] sample_in
  // result stream
  output logic                      m_axis_tvalid,
  input  wire                       m_axis_tready,
  output logic [15:0]               m_axis_tdata,   // [15:0] result_out
  output logic [0:0]                m_axis_tuser,   // [0] saturated
  // register writes
  input  wire                       cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [SAMPLE_W-1:0]       cfg_wdata_i
);

  // configuration registers
  logic signed [SAMPLE_W-1:0] tap_q [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] bias_q;
  logic                       silu_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TAPS; t++) tap_q[t] <= '0;
      bias_q    <= '0;
      silu_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        REG_TAP0, REG_TAP1, REG_TAP2, REG_TAP3: begin
          tap_q[cfg_index_i[TAP_IDX_W-1:0]] <= cfg_wdata_i;
        end
        REG_BIAS: bias_q    <= cfg_wdata_i;
        REG_SILU: silu_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  dwconv_state_e state_q, state_d;
  logic [TAP_IDX_W-1:0] cnt_q, cnt_d;
  logic                 in_fire;
  logic                 out_load;
  logic                 mac_last;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign mac_last = (cnt_q == TAP_IDX_W'(KERNEL - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cnt_d         = '0;
        if (s_axis_tvalid) state_d = ST_MAC;
      end
      ST_MAC: begin
        cnt_d = cnt_q + 1'b1;
        if (mac_last) state_d = ST_ROUND;
      end
      ST_ROUND: state_d = silu_en_q ? ST_SIG : ST_DONE;
      ST_SIG:   state_d = ST_SILU;
      ST_SILU:  state_d = ST_DONE;
      ST_DONE: begin
        // output register free or draining this cycle
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sample history, newest at the top entry
  logic signed [SAMPLE_W-1:0] hist_q [HIST_LEN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int h = 0; h < HIST_LEN; h++) hist_q[h] <= '0;
    end else if (in_fire) begin
      for (int h = 0; h + 1 < HIST_LEN; h++) hist_q[h] <= hist_q[h + 1];
      hist_q[HIST_LEN-1] <= s_axis_tdata;
    end
  end

  // window of KERNEL samples, oldest in entry 0; shifts down one per mac cycle
  logic signed [SAMPLE_W-1:0] win_q [KERNEL];

  for (genvar k = 0; k < KERNEL; k++) begin : g_win
    localparam int HistPos = HIST_LEN - (KERNEL - 1) + k;
    logic signed [SAMPLE_W-1:0] load_val;
    logic signed [SAMPLE_W-1:0] shift_val;

    if (k == KERNEL - 1) begin : g_new
      assign load_val  = s_axis_tdata;
      assign shift_val = '0;
    end else begin : g_old
      if (HistPos >= 0) begin : g_hist
        assign load_val = hist_q[HistPos];
      end else begin : g_zero
        // window reaches past the history: reads as zero
        assign load_val = '0;
      end
      assign shift_val = win_q[k + 1];
    end

    always_ff @(posedge clk_i) begin
      if (in_fire) begin
        win_q[k] <= load_val;
      end else if (state_q == ST_MAC) begin
        win_q[k] <= shift_val;
      end
    end
  end

  // shared multiplier and datapath
  logic signed [X_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [X_W-1:0]     x_q, x_d;
  logic signed [X_W-1:0]     y_q, y_d;
  logic [SIG_W-1:0]          s_q, s_d;

  logic [ACC_W-1:0]          round_sum;
  logic [X_W-1:0]            abs_x;
  logic                      sig_big;
  logic [2:0]                seg;
  logic [FRAC_W-1:0]         seg_frac;
  logic [15:0]               seg_lo;
  logic [15:0]               seg_delta;
  logic [26:0]               interp_sum;
  logic [SIG_W-1:0]          s_mag;
  logic [SIG_W-1:0]          s_pos;
  logic [PROD_W-1:0]         silu_sum;
  logic signed [SAMPLE_W-1:0] tap_sel;

  assign prod = mul_a * mul_b;

  assign tap_sel    = tap_q[cnt_q];
  assign round_sum  = acc_q + ACC_W'(2048);
  assign abs_x      = x_q[X_W-1] ? -x_q : x_q;
  assign sig_big    = |abs_x[X_W-1:15];
  assign seg        = abs_x[14:12];
  assign seg_frac   = abs_x[FRAC_W-1:0];
  assign seg_lo     = sig_lut({1'b0, seg});
  assign seg_delta  = sig_lut({1'b0, seg} + 4'd1) - seg_lo;
  assign interp_sum = prod[26:0] + 27'd2048;
  assign s_mag      = {1'b0, seg_lo} + SIG_W'(interp_sum[26:12]);
  assign s_pos      = sig_big ? SIG_ONE : s_mag;
  assign silu_sum   = prod + PROD_W'(32768);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    acc_d = acc_q;
    x_d   = x_q;
    y_d   = y_q;
    s_d   = s_q;
    case (state_q)
      ST_IDLE: begin
        // bias moved to the product scale
        acc_d = {{(ACC_W-SAMPLE_W-FRAC_W){bias_q[SAMPLE_W-1]}}, bias_q, {FRAC_W{1'b0}}};
      end
      ST_MAC: begin
        mul_a = {{(X_W-SAMPLE_W){win_q[0][SAMPLE_W-1]}}, win_q[0]};
        mul_b = {{(MUL_B_W-SAMPLE_W){tap_sel[SAMPLE_W-1]}}, tap_sel};
        acc_d = acc_q + prod[ACC_W-1:0];
      end
      ST_ROUND: begin
        // round half up, floor shift
        x_d = round_sum[ACC_W-1:FRAC_W];
        y_d = round_sum[ACC_W-1:FRAC_W];
      end
      ST_SIG: begin
        mul_a = {{(X_W-16){1'b0}}, seg_delta};
        mul_b = {{(MUL_B_W-FRAC_W){1'b0}}, seg_frac};
        s_d   = x_q[X_W-1] ? (SIG_ONE - s_pos) : s_pos;
      end
      ST_SILU: begin
        mul_a = x_q;
        mul_b = {1'b0, s_q};
        y_d   = silu_sum[16 +: X_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    s_q   <= s_d;
  end

  // clip to 16 bits
  logic                 clip;
  logic [SAMPLE_W-1:0]  clip_val;

  assign clip     = !((&y_q[X_W-1:SAMPLE_W-1]) || !(|y_q[X_W-1:SAMPLE_W-1]));
  assign clip_val = y_q[X_W-1] ? 16'h8000 : 16'h7fff;

  // output register
  logic                 m_valid_q;
  logic [SAMPLE_W-1:0]  res_q;
  logic                 sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= clip ? clip_val : y_q[SAMPLE_W-1:0];
      sat_q <= clip;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = res_q;
  assign m_axis_tuser[0] = sat_q;

  // checks
  a_accept_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_MAC)
    else $error("accepted beat did not start the mac sequence");

  a_mac_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MAC |-> cnt_q <= TAP_IDX_W'(KERNEL - 1))
    else $error("tap counter ran past the kernel");

  a_done_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && m_axis_tvalid && !m_axis_tready) |=> state_q == ST_DONE)
    else $error("result overwrote a stalled output beat");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && sat_q) |-> (res_q == 16'h7fff || res_q == 16'h8000))
    else $error("saturated flag set on an unclipped value");

endmodule

`default_nettype wire

// ===== verif/tb_causal_depthwise_conv_step_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for causal_depthwise_conv_step_top: directed and random sample
// beats under several idle/stall phases, results predicted by an in-bench scoreboard
// depends on dwconv_pkg and the rtl top level

module tb_causal_depthwise_conv_step_top;
  import dwconv_pkg::*;

  localparam int KERNEL         = KERNEL_DEF;
  localparam int HIST_LEN       = HIST_LEN_DEF;
  // worst case is roughly 600 beats
  localparam int TIMEOUT_CYCLES = 400000;
  // covers the slowest path through the block (silu on) with margin
  localparam int DRAIN_CYCLES   = 16;
  localparam int BLOCK_ITEMS    = 70;
  localparam int NUM_PHASES     = 4;
  localparam int BLOCKS_PER_PH  = 2;

  // register indexes past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 3'd7;

  // config styles for a random block
  localparam int CFG_ALL_MAX = 0;
  localparam int CFG_ALL_MIN = 1;
  localparam int CFG_RANDOM  = 2;

  typedef struct packed {
    logic [15:0] result;
    logic        sat;
  } conv_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of taps, bias, silu enable and sample history,
  // predicts one result per accepted sample and checks results in order
  // --------------------------------------------------------------------------
  class conv_scoreboard;
    logic signed [15:0] taps [NUM_TAPS];
    logic signed [15:0] bias;
    logic               silu_on;
    logic signed [15:0] history [HIST_LEN];
    conv_result_t       pending_results [$];
    int                 errors;

    function new();
      foreach (taps[i]) taps[i] = '0;
      foreach (history[i]) history[i] = '0;
      bias    = '0;
      silu_on = 1'b0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
      case (idx)
        REG_TAP0, REG_TAP1, REG_TAP2, REG_TAP3: taps[idx[TAP_IDX_W-1:0]] = data;
        REG_BIAS: bias = data;
        REG_SILU: silu_on = data[0];
        default: ;
      endcase
    endfunction

    // sigmoid at integer points 0..8, q.16
    function longint sig_point(int i);
      case (i)
        0: return 32768;
        1: return 47911;
        2: return 57724;
        3: return 62428;
        4: return 64357;
        5: return 65097;
        6: return 65374;
        7: return 65476;
        default: return 65514;
      endcase
    endfunction

    // piecewise-linear sigmoid of a q.12 value, result in q.16
    function longint sigmoid_q16(longint x);
      longint mag, s, lo, hi, frac;
      int     seg;
      mag = (x < 0) ? -x : x;
      if (mag >= 32768) begin
        s = 65536;
      end else begin
        seg  = int'(mag >>> 12);
        frac = mag & 4095;
        lo   = sig_point(seg);
        hi   = sig_point(seg + 1);
        s    = lo + (((hi - lo) * frac + 2048) >>> 12);
      end
      return (x < 0) ? 65536 - s : s;
    endfunction

    function void note_sample(logic [15:0] smp);
      longint       acc, v, x, y;
      int           p;
      conv_result_t r;
      acc = longint'(bias) * 4096;
      for (int j = 0; j < KERNEL && j < NUM_TAPS; j++) begin
        if (j == KERNEL - 1) begin
          v = longint'($signed(smp));
        end else begin
          // window positions older than the history read as zero
          p = HIST_LEN - (KERNEL - 1) + j;
          v = (p >= 0 && p < HIST_LEN) ? longint'(history[p]) : 0;
        end
        acc += longint'(taps[j]) * v;
      end
      x = (acc + 2048) >>> 12;
      y = silu_on ? ((x * sigmoid_q16(x) + 32768) >>> 16) : x;
      r.sat = 1'b0;
      if (y > 32767) begin
        y     = 32767;
        r.sat = 1'b1;
      end else if (y < -32768) begin
        y     = -32768;
        r.sat = 1'b1;
      end
      r.result = y[15:0];
      pending_results.push_back(r);
      for (int j = 0; j + 1 < HIST_LEN; j++) history[j] = history[j + 1];
      history[HIST_LEN-1] = smp;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic [15:0] res, logic sat);
      conv_result_t r;
      if (pending_results.size() == 0) begin
        report($sformatf("result %h sat %b with nothing expected", res, sat));
        return;
      end
      r = pending_results.pop_front();
      if (res !== r.result)
        report($sformatf("result_out expected %h actual %h", r.result, res));
      if (sat !== r.sat)
        report($sformatf("saturated expected %b actual %b (result %h)", r.sat, sat, res));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and dut
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata;    // [15:0] sample_in
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [15:0]          m_axis_tdata;    // [15:0] result_out
  logic [0:0]           m_axis_tuser;    // [0] saturated
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [SAMPLE_W-1:0]  cfg_wdata_i;

  conv_scoreboard sb;
  int             idle_pct;   // sender: chance per cycle of inserting an idle cycle
  int             stall_pct;  // receiver: chance per cycle of dropping tready
  int             cycle_count;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  causal_depthwise_conv_step_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // result side: check every accepted beat, then pick tready for the next edge
  // values read here are the ones from before the edge, so no race with the dut
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("tb_causal_depthwise_conv_step_top: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks, all entered and left right after a rising edge
  // --------------------------------------------------------------------------

  // one register write; write enable stays high so back-to-back writes chain
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [15:0] t0, input logic [15:0] t1,
                              input logic [15:0] t2, input logic [15:0] t3,
                              input logic [15:0] b,  input logic [15:0] silu);
    write_reg(REG_TAP0, t0);
    write_reg(REG_TAP1, t1);
    write_reg(REG_TAP2, t2);
    write_reg(REG_TAP3, t3);
    write_reg(REG_BIAS, b);
    write_reg(REG_SILU, silu);
    cfg_we_i <= 1'b0;
  endtask

  // small values keep most results out of saturation, full-range ones push into it
  function automatic logic [15:0] random_weight();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(8191)) - 16'd4096;
  endfunction

  task automatic random_config(input int style);
    case (style)
      CFG_ALL_MAX: program_regs(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0002);
      CFG_ALL_MIN: program_regs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
      default: begin
        // silu word is fully random, only bit 0 counts
        program_regs(random_weight(), random_weight(), random_weight(), random_weight(),
                     random_weight(), 16'($urandom));
      end
    endcase
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  // present one sample beat and wait for its accept; tvalid stays high afterwards
  // so the next beat can follow with no gap
  task automatic send_sample(input logic [15:0] smp);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(smp);
  endtask

  // stop sending and let every outstanding result come back, then let the block settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    // full-scale taps and bias: positive and negative saturation without silu
    logic [15:0] dir_max [11] = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                  16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                  16'h0000, 16'h0001, 16'hffff};
    // most negative taps and bias with silu: large negative x fades to near zero
    logic [15:0] dir_min [6]  = '{16'h8000, 16'h8000, 16'h8000,
                                  16'h7fff, 16'h7fff, 16'h7fff};
    // pass-through plus one lsb: hits x = 8.0 (top of the sigmoid table),
    // values just below it, table points and negative inputs
    logic [15:0] dir_pass [8] = '{16'h7fff, 16'h7ffe, 16'h8000, 16'h8001,
                                  16'h0000, 16'h0fff, 16'hefff, 16'h07ff};
    int          blk_no;

    sb            = new();
    cycle_count   = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, no idling on either side
    program_regs(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000);
    foreach (dir_max[i]) send_sample(dir_max[i]);
    drain_results();

    program_regs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0001);
    foreach (dir_min[i]) send_sample(dir_min[i]);
    drain_results();

    program_regs(16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0001, 16'hffff);
    @(posedge clk_i);
    // writes past the last register must leave the setup alone
    write_reg(REG_SPARE0, 16'($urandom));
    write_reg(REG_SPARE1, 16'h7fff);
    cfg_we_i <= 1'b0;
    foreach (dir_pass[i]) send_sample(dir_pass[i]);
    drain_results();

    // random part: phases of sender idling and receiver stalling, a fresh setup per block
    blk_no = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 85; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 9;  stall_pct = 9;  end
      endcase
      for (int blk = 0; blk < BLOCKS_PER_PH; blk++) begin
        if (blk_no == 0)      random_config(CFG_ALL_MAX);
        else if (blk_no == 5) random_config(CFG_ALL_MIN);
        else                  random_config(CFG_RANDOM);
        for (int k = 0; k < BLOCK_ITEMS; k++) begin
          // hold off mid-block until the pipe is empty, then restart the stream
          if (blk == 0 && k == BLOCK_ITEMS / 2) drain_results();
          send_sample(random_sample());
        end
        drain_results();
        blk_no++;
      end
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_causal_depthwise_conv_step_top: PASS");
    else
      $display("tb_causal_depthwise_conv_step_top: FAIL");
    $finish;
  end

endmodule
